### sv/hte_pkg.sv
// Package for the hash table engine: sizes, codes, request type and hash step.
package hte_pkg;
	localparam int Capacity  = 256;
	localparam int IdxW      = 8;
	localparam int CntW      = 9;
	localparam int KeyW      = 64;
	localparam int ValW      = 32;
	localparam int KeyBytes  = 8;
	localparam logic [31:0] FnvBasis = 32'd2166136261;
	localparam logic [31:0] FnvPrime = 32'd16777619;
	localparam logic [3:0]  StrideMask = 4'hF;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_NF   = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2,
		MARK_RSVD  = 2'd3
	} mark_t;

	// Hashed, normalized request handed from front to back
	typedef struct packed {
		op_t              op;
		logic [KeyW-1:0]  key;
		logic [3:0]       len;
		logic [ValW-1:0]  value;
		logic [31:0]      hash;
	} req_t;

	// One FNV-1a byte step
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FnvPrime;
	endfunction
endpackage

### sv/hash_table_engine.sv
// Top level of the hash table engine: front hasher, queue, probe engine.
//  channel   | handshake          | beat
//  request   | push / full        | opcode, key_bytes, key_length, value_in
//  result    | pop / empty        | status, value_out, slot_index, live_entries
// The front hashes one key byte per cycle and hands off through a
// two-entry queue. The probe engine takes a request, probes each slot
// with a registered memory read then a compare until a hit or an empty
// slot ends the walk, and ends with the slot update and the result; an
// insert that reuses a tombstone first moves its write slot to it.
// After reset all slot marks are swept to empty; requests
// queue up meanwhile. A result not popped holds the engine; the queue and
// then the front fill up behind it.
module hash_table_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [31:0] value_in,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	output logic [7:0]  slot_index,
	output logic [8:0]  live_entries
);
	import hte_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready, clearing;
	req_t f_req, q_req;

	hte_front u_front (
		.clk, .arst_n, .push, .full, .opcode, .key_bytes, .key_length, .value_in,
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	hte_fifo u_fifo (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
	);

	hte_back u_back (
		.clk, .arst_n, .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.empty, .pop, .status, .value_out, .slot_index, .live_entries, .clearing
	);

	// No request leaves the queue during the clearing sweep
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_ready) else $error("request taken while clearing");
	// Live count never exceeds capacity
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> live_entries <= 9'(Capacity)) else $error("live count overflow");
	// Miss results carry slot 0 and no value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_NF || status == ST_FULL)) |-> (slot_index == 8'd0
		&& value_out == 32'd0)) else $error("miss with payload");
endmodule

### sv/hte_front.sv
// Front end: normalizes the key and hashes it one byte per cycle.
module hte_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      opcode,
	input  logic [63:0]     key_bytes,
	input  logic [3:0]      key_length,
	input  logic [31:0]     value_in,
	output logic            req_valid,
	input  logic            req_ready,
	output hte_pkg::req_t   req
);
	import hte_pkg::*;

	logic        busy_q, done_q;
	logic [3:0]  len_q, cnt_q;
	logic [31:0] hash_q;
	req_t        req_q;
	logic [3:0]  len_n;
	logic [63:0] kmask;

	// Clamp length to 1..8 and mask unused bytes
	always_comb begin
		len_n = key_length;
		if (len_n == 4'd0) len_n = 4'd1;
		if (len_n > 4'(KeyBytes)) len_n = 4'(KeyBytes);
		kmask = '1;
		if (len_n < 4'd8) kmask = (64'd1 << {len_n, 3'b000}) - 64'd1;
	end

	assign full      = busy_q;
	assign req_valid = done_q;
	always_comb begin
		req = req_q;
		req.hash = hash_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (!busy_q && push) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (busy_q && !done_q && cnt_q == len_q) begin
				done_q <= 1'b1;
			end else if (done_q && req_ready) begin
				done_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	// Payload and hash iteration
	always_ff @(posedge clk) begin
		if (!busy_q && push) begin
			req_q.op    <= op_t'(opcode);
			req_q.key   <= key_bytes & kmask;
			req_q.len   <= len_n;
			req_q.value <= value_in;
			req_q.hash  <= '0;
			len_q       <= len_n;
			cnt_q       <= 4'd0;
			hash_q      <= FnvBasis;
		end else if (busy_q && !done_q && cnt_q != len_q) begin
			hash_q <= fnv_step(hash_q, req_q.key[{cnt_q[2:0], 3'b000} +: 8]);
			cnt_q  <= cnt_q + 4'd1;
		end
	end
endmodule

### sv/hte_fifo.sv
// Two-entry queue between the front end and the probe engine.
module hte_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hte_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hte_pkg::req_t out_data
);
	import hte_pkg::*;

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end
endmodule

### sv/hte_back.sv
// Probe engine: walks the slot store, applies the request, holds the result in a result register.
module hte_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hte_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output logic [1:0]    status,
	output logic [31:0]   value_out,
	output logic [7:0]    slot_index,
	output logic [8:0]    live_entries,
	output logic          clearing
);
	import hte_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_READ  = 6'b000100,
		S_CHECK = 6'b001000,
		S_DONE  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// Slot store: key, length, value, mark
	logic [KeyW-1:0] key_mem [Capacity];
	logic [3:0]      len_mem [Capacity];
	logic [ValW-1:0] val_mem [Capacity];
	mark_t           mark_mem [Capacity];
	logic [KeyW-1:0] rd_key_q;
	logic [3:0]      rd_len_q;
	logic [ValW-1:0] rd_val_q;
	mark_t           rd_mark_q;

	req_t            cur_q;
	logic [IdxW-1:0] idx_q, stride_q, tomb_q, slot_q;
	logic [IdxW:0]   step_q;
	logic            pass_q, has_tomb_q, hit_q, has_empty_q;
	logic [CntW-1:0] live_q, tomb_cnt_q;

	logic            mwe;
	logic [IdxW-1:0] maddr;
	mark_t           mdata;
	logic            dwe;

	// Result register
	logic            rvalid_q;
	logic [1:0]      rstat_q;
	logic [ValW-1:0] rval_q;
	logic [IdxW-1:0] rslot_q;
	logic [CntW-1:0] rlive_q;

	assign req_ready    = state_q == S_IDLE;
	assign clearing     = state_q == S_CLEAR;
	assign empty        = !rvalid_q;
	assign status       = rstat_q;
	assign value_out    = rval_q;
	assign slot_index   = rslot_q;
	assign live_entries = rlive_q;

	// Mark and data write selection; an insert waits until slot_q holds the first tombstone
	always_comb begin
		mwe = 1'b0;
		maddr = idx_q;
		mdata = MARK_EMPTY;
		dwe = 1'b0;
		if (state_q == S_CLEAR) begin
			mwe = 1'b1;
		end else if (state_q == S_DONE) begin
			maddr = slot_q;
			if (cur_q.op == OP_INSERT && !hit_q && (has_tomb_q || has_empty_q)
					&& !(has_tomb_q && slot_q != tomb_q)) begin
				mwe = 1'b1; mdata = MARK_LIVE; dwe = 1'b1;
			end else if (cur_q.op == OP_REMOVE && hit_q) begin
				mwe = 1'b1; mdata = MARK_TOMB;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mwe) mark_mem[maddr] <= mdata;
		if (dwe) begin
			key_mem[maddr] <= cur_q.key;
			len_mem[maddr] <= cur_q.len;
			val_mem[maddr] <= cur_q.value;
		end
		rd_mark_q <= mark_mem[idx_q];
		rd_key_q  <= key_mem[idx_q];
		rd_len_q  <= len_mem[idx_q];
		rd_val_q  <= val_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			idx_q      <= '0;
			live_q     <= '0;
			tomb_cnt_q <= '0;
			rvalid_q   <= 1'b0;
		end else begin
			// S_OUT reloads the result register itself
			if (pop && rvalid_q && state_q != S_OUT) rvalid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IdxW'(Capacity - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						cur_q       <= req;
						idx_q       <= req.hash[IdxW-1:0];
						stride_q    <= (req.hash[3:0] & StrideMask) == 4'd0 ? IdxW'(1)
							: IdxW'(req.hash[3:0] & StrideMask);
						step_q      <= '0;
						pass_q      <= 1'b0;
						has_tomb_q  <= 1'b0;
						hit_q       <= 1'b0;
						has_empty_q <= 1'b0;
						slot_q      <= '0;
						state_q     <= (req.op == OP_NONE) ? S_DONE : S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (rd_mark_q == MARK_EMPTY) begin
						has_empty_q <= 1'b1;
						slot_q <= idx_q;
						state_q <= S_DONE;
					end else if (rd_mark_q == MARK_LIVE && rd_len_q == cur_q.len
							&& rd_key_q == cur_q.key) begin
						hit_q <= 1'b1;
						slot_q <= idx_q;
						state_q <= S_DONE;
					end else begin
						if (rd_mark_q != MARK_LIVE && !has_tomb_q) begin
							has_tomb_q <= 1'b1;
							tomb_q <= idx_q;
						end
						idx_q <= idx_q + stride_q;
						if (step_q == (IdxW+1)'(Capacity - 1)) begin
							step_q <= '0;
							stride_q <= IdxW'(1);
							pass_q <= 1'b1;
							state_q <= pass_q ? S_DONE : S_READ;
						end else begin
							step_q <= step_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_DONE: begin
					// slot_q used as write address here; tombstone chosen on insert
					if (cur_q.op == OP_INSERT && !hit_q && has_tomb_q && slot_q != tomb_q) begin
						slot_q <= tomb_q;
						has_empty_q <= 1'b0;
					end else begin
						state_q <= S_OUT;
						if (mwe && mdata == MARK_LIVE) begin
							live_q <= live_q + 1'b1;
							if (has_tomb_q && tomb_cnt_q != '0) tomb_cnt_q <= tomb_cnt_q - 1'b1;
						end else if (mwe && mdata == MARK_TOMB) begin
							if (live_q != '0) live_q <= live_q - 1'b1;
							tomb_cnt_q <= tomb_cnt_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					if (!rvalid_q || pop) begin
						rvalid_q <= 1'b1;
						rlive_q  <= live_q;
						rval_q   <= '0;
						rslot_q  <= '0;
						rstat_q  <= ST_NF;
						state_q  <= S_IDLE;
						case (cur_q.op)
							OP_INSERT: begin
								if (hit_q) begin
									rstat_q <= ST_DUP; rslot_q <= slot_q;
								end else if (has_tomb_q || has_empty_q) begin
									rstat_q <= ST_OK; rslot_q <= slot_q;
								end else begin
									rstat_q <= ST_FULL;
								end
							end
							OP_FIND: begin
								if (hit_q) begin
									rstat_q <= ST_OK; rslot_q <= slot_q; rval_q <= rd_val_q;
								end
							end
							OP_REMOVE: begin
								if (hit_q) begin
									rstat_q <= ST_OK; rslot_q <= slot_q;
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
